>>> sv/ivd_pkg.sv
package ivd_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CONST_BITS = 24;
    localparam int MAX_SIDE   = 1024;

    localparam logic [23:0] K_INV_PHI  = 24'd10368890;
    localparam logic [23:0] K_INV_PHI2 = 24'd6408326;
    localparam logic [23:0] K_PHI_RT3  = 24'd15672811;
    localparam logic [23:0] K_IPHI_RT3 = 24'd5986481;
    localparam logic [23:0] K_INV_RT3  = 24'd9686330;
    localparam logic [23:0] K_INRAD    = 24'd13332090;

    localparam logic [2:0] REG_GRID_SIDE = 3'd0;
    localparam logic [2:0] REG_RADIUS    = 3'd1;
    localparam logic [2:0] REG_ROTATE    = 3'd2;
    localparam logic [2:0] REG_QUAT_W    = 3'd3;
    localparam logic [2:0] REG_QUAT_X    = 3'd4;
    localparam logic [2:0] REG_QUAT_Y    = 3'd5;
    localparam logic [2:0] REG_QUAT_Z    = 3'd6;

    localparam logic [1:0] FACE_EDGE_ONE   = 2'd0;
    localparam logic [1:0] FACE_EDGE_TWO   = 2'd1;
    localparam logic [1:0] FACE_EDGE_THREE = 2'd2;
    localparam logic [1:0] FACE_CENTRE     = 2'd3;

    typedef enum logic [1:0] {
        MX_IDLE,
        MX_SQUARES,
        MX_PRODUCTS,
        MX_DIVIDE
    } mx_state_t;

endpackage

>>> sv/ivd_matrix.sv
module ivd_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic signed [17:0] matrix [9],
    output logic               busy
);

    ivd_pkg::mx_state_t state_reg, state_next;

    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic [33:0]        norm_reg;
    logic signed [34:0] num_reg [9];
    logic [3:0]         elem_reg, elem_next;
    logic [5:0]         bit_reg, bit_next;
    logic [50:0]        rem_reg, rem_next;
    logic [50:0]        dvd_reg, dvd_next;
    logic [50:0]        quo_reg, quo_next;
    logic signed [17:0] matrix_reg [9];
    logic [50:0]        shifted;
    logic [50:0]        mag_num;
    logic [51:0]        rounded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ivd_pkg::MX_SQUARES;
            elem_reg  <= '0;
            bit_reg   <= '0;
            for (int i = 0; i < 9; i++)
            begin
                matrix_reg[i] <= (i % 4 == 0) ? 18'sd65536 : 18'sd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            bit_reg   <= bit_next;
            if (state_reg == ivd_pkg::MX_DIVIDE && bit_reg == 6'd0)
            begin
                if (norm_reg == '0)
                begin
                    matrix_reg[elem_reg] <= (elem_reg == 4'd0 || elem_reg == 4'd4 ||
                                             elem_reg == 4'd8) ? 18'sd65536 : 18'sd0;
                end
                else
                begin
                    matrix_reg[elem_reg] <= num_reg[elem_reg][34]
                        ? -$signed(quo_next[17:0]) : $signed(quo_next[17:0]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ivd_pkg::MX_SQUARES)
        begin
            ww_reg <= quat_w * quat_w;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            wz_reg <= quat_w * quat_z;
            xz_reg <= quat_x * quat_z;
            wy_reg <= quat_w * quat_y;
            yz_reg <= quat_y * quat_z;
            wx_reg <= quat_w * quat_x;
        end
        if (state_reg == ivd_pkg::MX_PRODUCTS)
        begin
            norm_reg   <= 34'(ww_reg) + 34'(xx_reg) + 34'(yy_reg) + 34'(zz_reg);
            num_reg[0] <= 35'(ww_reg) + 35'(xx_reg) - 35'(yy_reg) - 35'(zz_reg);
            num_reg[1] <= (35'(xy_reg) - 35'(wz_reg)) <<< 1;
            num_reg[2] <= (35'(xz_reg) + 35'(wy_reg)) <<< 1;
            num_reg[3] <= (35'(xy_reg) + 35'(wz_reg)) <<< 1;
            num_reg[4] <= 35'(ww_reg) - 35'(xx_reg) + 35'(yy_reg) - 35'(zz_reg);
            num_reg[5] <= (35'(yz_reg) - 35'(wx_reg)) <<< 1;
            num_reg[6] <= (35'(xz_reg) - 35'(wy_reg)) <<< 1;
            num_reg[7] <= (35'(yz_reg) + 35'(wx_reg)) <<< 1;
            num_reg[8] <= 35'(ww_reg) - 35'(xx_reg) - 35'(yy_reg) + 35'(zz_reg);
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        mag_num    = num_reg[elem_reg][34] ? 51'(-num_reg[elem_reg]) : 51'(num_reg[elem_reg]);
        rounded    = 52'({mag_num, 16'd0}) + 52'(norm_reg >> 1);
        shifted    = {rem_reg[49:0], dvd_reg[50]};
        unique case (state_reg)
            ivd_pkg::MX_IDLE:
            begin
                state_next = ivd_pkg::MX_IDLE;
            end
            ivd_pkg::MX_SQUARES:
            begin
                state_next = ivd_pkg::MX_PRODUCTS;
            end
            ivd_pkg::MX_PRODUCTS:
            begin
                state_next = ivd_pkg::MX_DIVIDE;
                elem_next  = '0;
                bit_next   = 6'd51;
            end
            ivd_pkg::MX_DIVIDE:
            begin
                if (bit_reg == 6'd51)
                begin
                    rem_next = '0;
                    dvd_next = rounded[50:0];
                    quo_next = '0;
                    bit_next = 6'd50;
                end
                else
                begin
                    if (shifted >= 51'(norm_reg))
                    begin
                        rem_next = shifted - 51'(norm_reg);
                        quo_next = {quo_reg[49:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = shifted;
                        quo_next = {quo_reg[49:0], 1'b0};
                    end
                    dvd_next = {dvd_reg[49:0], 1'b0};
                    if (bit_reg == 6'd0)
                    begin
                        bit_next = 6'd51;
                        if (elem_reg == 4'd8)
                        begin
                            state_next = ivd_pkg::MX_IDLE;
                        end
                        else
                        begin
                            elem_next = elem_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        bit_next = bit_reg - 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = ivd_pkg::MX_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = ivd_pkg::MX_SQUARES;
        end
    end

    assign busy = (state_reg != ivd_pkg::MX_IDLE);

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            matrix[i] = matrix_reg[i];
        end
    end

endmodule

>>> sv/icosahedron_voxel_density_unit.sv
// Icosahedron voxel density unit.
// Input stream s_axis: one voxel index triple per item, accepted when
// s_axis_tvalid and s_axis_tready are high. Output stream m_axis: one item per
// input, carrying density (Q1.16) and the chosen face in tuser.
// Configuration: cfg_we writes register cfg_index with cfg_data at a clock edge;
// the user must write only while the stream is idle, which the block does not
// enforce. After a quaternion write the rotation matrix is rebuilt by a shared
// serial divider, one quotient bit per cycle over nine entries; a rotated item
// may be sent only once the rebuild is done. One item per cycle is sustained
// while the output is not stalled. The six stages each hold a valid bit and
// advance together; when the last stage holds an item and the receiver holds
// m_axis_tready low the whole pipe holds, and tready stays high as long as the
// last stage is empty or draining, so no item is lost or repeated.
// Reset clears all valid bits, loads the register reset values and the
// identity matrix; the matrix is rebuilt from the reset quaternion afterwards.
module icosahedron_voxel_density_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // x_index[9:0], y_index[19:10], z_index[29:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // density[16:0]
    output logic [1:0]  m_axis_tuser,   // face_region[1:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int NS = 6;

    logic [10:0]        grid_side_reg;
    logic [23:0]        radius_reg;
    logic               rotate_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic               mx_start;
    logic               mx_busy;
    logic signed [17:0] mtx [9];

    logic [NS-1:0]      vld_reg;
    logic               adv;

    logic [10:0]        side_eff;
    logic [31:0]        d_inrad_reg;
    logic [23:0]        rad_eff;
    logic [47:0]        inrad_prod;

    // stage 1: centred coordinates
    logic signed [11:0] h_reg [3];
    logic               rot1_reg;
    // stage 2: rotated products
    logic signed [30:0] p_reg [9];
    logic               rot2_reg;
    // stage 3: folded coordinates
    logic [26:0]        c_reg [3];
    // stage 4: edge test products
    logic [50:0]        ta_reg [3];
    logic [51:0]        tb_reg [3];
    logic [26:0]        c4_reg [3];
    // stage 5: face choice and distance
    logic [1:0]         face5_reg;
    logic [52:0]        acc5_reg;
    // stage 6: output
    logic [16:0]        dens_reg;
    logic [1:0]         face6_reg;

    logic [11:0]        side2;
    logic signed [32:0] sum_rot [3];
    logic [32:0]        mag_rot [3];
    logic [26:0]        c_next [3];
    logic [1:0]         face_next;
    logic [26:0]        ca, cb;
    logic [28:0]        csum;
    logic [52:0]        acc_next;
    logic [28:0]        d_val;
    logic signed [33:0] val;
    logic [16:0]        dens_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= 11'd64;
            radius_reg    <= 24'd5120;
            rotate_reg    <= 1'b0;
            qw_reg        <= 16'sd32767;
            qx_reg        <= '0;
            qy_reg        <= '0;
            qz_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ivd_pkg::REG_GRID_SIDE: grid_side_reg <= cfg_data[10:0];
                ivd_pkg::REG_RADIUS:    radius_reg    <= cfg_data;
                ivd_pkg::REG_ROTATE:    rotate_reg    <= cfg_data[0];
                ivd_pkg::REG_QUAT_W:    qw_reg        <= cfg_data[15:0];
                ivd_pkg::REG_QUAT_X:    qx_reg        <= cfg_data[15:0];
                ivd_pkg::REG_QUAT_Y:    qy_reg        <= cfg_data[15:0];
                ivd_pkg::REG_QUAT_Z:    qz_reg        <= cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    assign mx_start = cfg_we && (cfg_index == ivd_pkg::REG_QUAT_W ||
                                 cfg_index == ivd_pkg::REG_QUAT_X ||
                                 cfg_index == ivd_pkg::REG_QUAT_Y ||
                                 cfg_index == ivd_pkg::REG_QUAT_Z);

    ivd_matrix u_matrix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mx_start),
        .quat_w (qw_reg),
        .quat_x (qx_reg),
        .quat_y (qy_reg),
        .quat_z (qz_reg),
        .matrix (mtx),
        .busy   (mx_busy)
    );

    // Inradius in Q.16, from the radius register alone.
    always_comb
    begin
        rad_eff    = (radius_reg == '0) ? 24'd1 : radius_reg;
        inrad_prod = rad_eff * ivd_pkg::K_INRAD;
    end

    always_ff @(posedge clk)
    begin
        d_inrad_reg <= 32'((inrad_prod + 48'(1 << 15)) >> 16);
    end

    assign adv           = !vld_reg[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
        end
    end

    always_comb
    begin
        side_eff = (grid_side_reg == '0) ? 11'd1 :
                   (grid_side_reg > 11'(ivd_pkg::MAX_SIDE)) ? 11'(ivd_pkg::MAX_SIDE) :
                   grid_side_reg;
        side2 = 12'(side_eff);
        for (int k = 0; k < 3; k++)
        begin
            sum_rot[k] = 33'(p_reg[k]) + 33'(p_reg[k+3]) + 33'(p_reg[k+6]);
            mag_rot[k] = sum_rot[k][32] ? 33'(-sum_rot[k]) : 33'(sum_rot[k]);
            if (rot2_reg)
            begin
                c_next[k] = 27'((mag_rot[k] + 33'd1) >> 1);
            end
            else
            begin
                c_next[k] = {p_reg[4*k][11] ? 12'(-p_reg[4*k][11:0]) : p_reg[4*k][11:0],
                             15'd0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg[0] <= $signed({1'b0, s_axis_tdata[29:20], 1'b1}) - $signed(side2);
            h_reg[1] <= $signed({1'b0, s_axis_tdata[19:10], 1'b1}) - $signed(side2);
            h_reg[2] <= $signed({1'b0, s_axis_tdata[9:0], 1'b1}) - $signed(side2);
            rot1_reg <= rotate_reg;

            // products: row i of input (z,y,x) times matrix columns; output Z,Y,X
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (rot1_reg)
                    begin
                        p_reg[3*r+k] <= h_reg[r] * mtx[3*r+k];
                    end
                    else
                    begin
                        p_reg[3*r+k] <= (r == k) ? 31'(h_reg[r]) : 31'sd0;
                    end
                end
            end
            rot2_reg <= rot1_reg;

            // c_reg order: Z, Y, X
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k] <= c_next[k];
            end

            // edge tests: pair (a,b,c) = (Y,X,Z), (Z,Y,X), (X,Z,Y)
            ta_reg[0] <= c_reg[1] * ivd_pkg::K_INV_PHI;
            tb_reg[0] <= 52'(c_reg[2] * ivd_pkg::K_INV_PHI2) + {1'b0, c_reg[0], 24'd0};
            ta_reg[1] <= c_reg[0] * ivd_pkg::K_INV_PHI;
            tb_reg[1] <= 52'(c_reg[1] * ivd_pkg::K_INV_PHI2) + {1'b0, c_reg[2], 24'd0};
            ta_reg[2] <= c_reg[2] * ivd_pkg::K_INV_PHI;
            tb_reg[2] <= 52'(c_reg[0] * ivd_pkg::K_INV_PHI2) + {1'b0, c_reg[1], 24'd0};
            for (int k = 0; k < 3; k++)
            begin
                c4_reg[k] <= c_reg[k];
            end

            face5_reg <= face_next;
            acc5_reg  <= acc_next;

            dens_reg  <= dens_next;
            face6_reg <= face5_reg;
        end
    end

    always_comb
    begin
        priority if (52'(ta_reg[0]) > tb_reg[0])
        begin
            face_next = ivd_pkg::FACE_EDGE_ONE;
            ca = c4_reg[1];
            cb = c4_reg[2];
        end
        else if (52'(ta_reg[1]) > tb_reg[1])
        begin
            face_next = ivd_pkg::FACE_EDGE_TWO;
            ca = c4_reg[0];
            cb = c4_reg[1];
        end
        else if (52'(ta_reg[2]) > tb_reg[2])
        begin
            face_next = ivd_pkg::FACE_EDGE_THREE;
            ca = c4_reg[2];
            cb = c4_reg[0];
        end
        else
        begin
            face_next = ivd_pkg::FACE_CENTRE;
            ca = c4_reg[0];
            cb = c4_reg[1];
        end
        csum = 29'(c4_reg[0]) + 29'(c4_reg[1]) + 29'(c4_reg[2]);
        if (face_next == ivd_pkg::FACE_CENTRE)
        begin
            acc_next = 53'(csum * ivd_pkg::K_INV_RT3);
        end
        else
        begin
            acc_next = 53'(ca * ivd_pkg::K_PHI_RT3) + 53'(cb * ivd_pkg::K_IPHI_RT3);
        end
    end

    always_comb
    begin
        d_val = 29'((acc5_reg + 53'(1 << 23)) >> 24);
        val   = $signed({2'b0, d_inrad_reg}) + 34'sd32768 - $signed({5'b0, d_val});
        if (val < 0)
        begin
            dens_next = '0;
        end
        else if (val > 34'sd65536)
        begin
            dens_next = 17'd65536;
        end
        else
        begin
            dens_next = val[16:0];
        end
    end

    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = {7'd0, dens_reg};
    assign m_axis_tuser  = face6_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipe stalled with empty output");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'd65536)
        else $error("density above one");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && !vld_reg[NS-2] |=> !m_axis_tvalid)
        else $error("item invented");
    a_settled: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && rotate_reg |-> !mx_busy)
        else $error("rotated item taken while matrix rebuilds");

endmodule

>>> tb/sv/tb_icosahedron_voxel_density_unit.sv
`timescale 1ns / 1ps

module tb_icosahedron_voxel_density_unit;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam int MATRIX_SETTLE = 600;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    typedef struct {
        logic [16:0] density;
        logic [1:0]  face;
    } voxel_result_t;

    voxel_result_t density_q[$];

    longint cur_side;
    longint cur_radius;
    bit     cur_rotate;
    longint cur_quat[4];
    longint rot_m[9];

    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  face_hits[4];
    bit  gaps_on;
    bit  stalls_on;
    int  hold_left;

    icosahedron_voxel_density_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint to_q16(longint num, longint den);
        longint q;
        q = ((magnitude(num) << ivd_pkg::FRAC_BITS) + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic void build_rotation();
        longint w, x, y, z, ww, xx, yy, zz, n;
        longint num[9];
        w = cur_quat[0]; x = cur_quat[1]; y = cur_quat[2]; z = cur_quat[3];
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        n = ww + xx + yy + zz;
        if (n == 0)
        begin
            for (int i = 0; i < 9; i++)
                rot_m[i] = (i % 4 == 0) ? (64'sd1 <<< ivd_pkg::FRAC_BITS) : 0;
            return;
        end
        num[0] = ww + xx - yy - zz;
        num[1] = 2 * (x * y - w * z);
        num[2] = 2 * (x * z + w * y);
        num[3] = 2 * (x * y + w * z);
        num[4] = ww - xx + yy - zz;
        num[5] = 2 * (y * z - w * x);
        num[6] = 2 * (x * z - w * y);
        num[7] = 2 * (y * z + w * x);
        num[8] = ww - xx - yy + zz;
        for (int i = 0; i < 9; i++)
            rot_m[i] = to_q16(num[i], n);
    endfunction

    function automatic voxel_result_t voxel_density(logic [9:0] xi, logic [9:0] yi,
                                                    logic [9:0] zi);
        voxel_result_t r;
        longint side, hx, hy, hz, px, py, pz, acc, d, dd, rad, val;
        longint k_one;
        k_one = 64'sd1 <<< ivd_pkg::CONST_BITS;
        side = cur_side;
        if (side < 1) side = 1;
        if (side > ivd_pkg::MAX_SIDE) side = ivd_pkg::MAX_SIDE;
        hx = 2 * longint'(xi) + 1 - side;
        hy = 2 * longint'(yi) + 1 - side;
        hz = 2 * longint'(zi) + 1 - side;
        if (cur_rotate)
        begin
            pz = (magnitude(hz * rot_m[0] + hy * rot_m[3] + hx * rot_m[6]) + 1) >> 1;
            py = (magnitude(hz * rot_m[1] + hy * rot_m[4] + hx * rot_m[7]) + 1) >> 1;
            px = (magnitude(hz * rot_m[2] + hy * rot_m[5] + hx * rot_m[8]) + 1) >> 1;
        end
        else
        begin
            pz = magnitude(hz) << (ivd_pkg::FRAC_BITS - 1);
            py = magnitude(hy) << (ivd_pkg::FRAC_BITS - 1);
            px = magnitude(hx) << (ivd_pkg::FRAC_BITS - 1);
        end
        if (ivd_pkg::K_INV_PHI * py > ivd_pkg::K_INV_PHI2 * px + k_one * pz)
        begin
            r.face = ivd_pkg::FACE_EDGE_ONE;
            acc = py * ivd_pkg::K_PHI_RT3 + px * ivd_pkg::K_IPHI_RT3;
        end
        else if (ivd_pkg::K_INV_PHI * pz > ivd_pkg::K_INV_PHI2 * py + k_one * px)
        begin
            r.face = ivd_pkg::FACE_EDGE_TWO;
            acc = pz * ivd_pkg::K_PHI_RT3 + py * ivd_pkg::K_IPHI_RT3;
        end
        else if (ivd_pkg::K_INV_PHI * px > ivd_pkg::K_INV_PHI2 * pz + k_one * py)
        begin
            r.face = ivd_pkg::FACE_EDGE_THREE;
            acc = px * ivd_pkg::K_PHI_RT3 + pz * ivd_pkg::K_IPHI_RT3;
        end
        else
        begin
            r.face = ivd_pkg::FACE_CENTRE;
            acc = (px + py + pz) * ivd_pkg::K_INV_RT3;
        end
        d = (acc + (64'sd1 <<< (ivd_pkg::CONST_BITS - 1))) >> ivd_pkg::CONST_BITS;
        rad = (cur_radius == 0) ? 1 : cur_radius;
        dd = (rad * ivd_pkg::K_INRAD + (64'sd1 <<< (31 - ivd_pkg::FRAC_BITS)))
             >> (32 - ivd_pkg::FRAC_BITS);
        val = (64'sd1 <<< (ivd_pkg::FRAC_BITS - 1)) + dd - d;
        if (val < 0) val = 0;
        if (val > (64'sd1 <<< ivd_pkg::FRAC_BITS)) val = 64'sd1 <<< ivd_pkg::FRAC_BITS;
        r.density = val[16:0];
        return r;
    endfunction

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            ivd_pkg::REG_GRID_SIDE: cur_side   = value[10:0];
            ivd_pkg::REG_RADIUS:    cur_radius = value;
            ivd_pkg::REG_ROTATE:    cur_rotate = value[0];
            ivd_pkg::REG_QUAT_W, ivd_pkg::REG_QUAT_X,
            ivd_pkg::REG_QUAT_Y, ivd_pkg::REG_QUAT_Z:
            begin
                cur_quat[idx - ivd_pkg::REG_QUAT_W] = longint'($signed(value[15:0]));
                build_rotation();
            end
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (density_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_shape(int side, int radius, bit rot);
        drain();
        write_reg(ivd_pkg::REG_GRID_SIDE, 24'(side));
        write_reg(ivd_pkg::REG_RADIUS, 24'(radius));
        write_reg(ivd_pkg::REG_ROTATE, 24'(rot));
    endtask

    task automatic set_quat(int w, int x, int y, int z);
        drain();
        write_reg(ivd_pkg::REG_QUAT_W, 24'(w[15:0]));
        write_reg(ivd_pkg::REG_QUAT_X, 24'(x[15:0]));
        write_reg(ivd_pkg::REG_QUAT_Y, 24'(y[15:0]));
        write_reg(ivd_pkg::REG_QUAT_Z, 24'(z[15:0]));
        repeat (MATRIX_SETTLE) @(posedge clk);
    endtask

    task automatic send_voxel(logic [9:0] xi, logic [9:0] yi, logic [9:0] zi);
        int gap;
        gap = pick_gap(gaps_on);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, zi, yi, xi};
        do @(posedge clk); while (!s_axis_tready);
        density_q.push_back(voxel_density(xi, yi, zi));
        items_sent++;
    endtask

    function automatic logic [9:0] rand_index(longint side);
        int lim;
        lim = (side < 1) ? 1 : (side > ivd_pkg::MAX_SIDE ? ivd_pkg::MAX_SIDE : int'(side));
        if ($urandom_range(0, 9) < 7) return 10'($urandom_range(0, lim - 1));
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++)
            send_voxel(rand_index(cur_side), rand_index(cur_side), rand_index(cur_side));
    endtask

    task automatic test_directed();
        send_voxel(10'd0, 10'd0, 10'd0);
        send_voxel(10'd1023, 10'd1023, 10'd1023);
        send_voxel(10'd31, 10'd32, 10'd33);
        send_voxel(10'd63, 10'd0, 10'd32);
        send_voxel(10'd32, 10'd63, 10'd0);
        send_voxel(10'd0, 10'd32, 10'd63);
        send_voxel(10'd40, 10'd40, 10'd40);
        // zero coordinate sum at the exact centre of an odd grid
        set_shape(63, 4000, 1'b0);
        send_voxel(10'd31, 10'd31, 10'd31);
        send_voxel(10'd31, 10'd31, 10'd32);
        // side and radius out of range
        set_shape(0, 0, 1'b0);
        send_voxel(10'd0, 10'd0, 10'd0);
        send_voxel(10'd1, 10'd0, 10'd1);
        set_shape(2047, 24'hFFFFFF, 1'b0);
        send_voxel(10'd512, 10'd511, 10'd0);
        send_voxel(10'd1023, 10'd0, 10'd1023);
        set_shape(1024, 130000, 1'b0);
        send_voxel(10'd0, 10'd512, 10'd512);
        send_voxel(10'd700, 10'd300, 10'd600);
        // ignored register index must leave the settings alone
        drain();
        write_reg(REG_UNUSED, 24'hABCDEF);
        send_voxel(10'd700, 10'd300, 10'd600);
        // zero quaternion falls back to the identity
        set_quat(0, 0, 0, 0);
        set_shape(64, 5120, 1'b1);
        send_voxel(10'd10, 10'd50, 10'd20);
        send_voxel(10'd0, 10'd63, 10'd5);
        set_quat(-32768, 32767, -32768, 32767);
        send_voxel(10'd10, 10'd50, 10'd20);
        send_voxel(10'd1023, 10'd0, 10'd511);
        set_quat(23170, 0, 0, 23170);
        send_voxel(10'd60, 10'd3, 10'd30);
        send_voxel(10'd3, 10'd60, 10'd30);
    endtask

    task automatic test_random_settings();
        int side;
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: side = 1;
                1: side = 1024;
                2: side = 2;
                default: side = $urandom_range(3, 200);
            endcase
            gaps_on   = (p % 4 != 1);
            stalls_on = (p % 4 != 2);
            if (p % 3 == 2)
                set_quat($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                         $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
            set_shape(side, (p == 3) ? 1 : side * $urandom_range(70, 190),
                      p % 2);
            random_burst(150);
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_backpressure();
        set_shape(96, 96 * 128, 1'b1);
        gaps_on = 1'b0;
        hold_left = 300;
        random_burst(60);
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        voxel_result_t exp_r;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (density_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: density %0d face %0d",
                             m_axis_tdata[16:0], m_axis_tuser);
            end
            else
            begin
                exp_r = density_q.pop_front();
                face_hits[exp_r.face]++;
                if (m_axis_tdata[16:0] !== exp_r.density || m_axis_tuser !== exp_r.face)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: density exp %0d got %0d, face exp %0d got %0d",
                                 exp_r.density, m_axis_tdata[16:0], exp_r.face,
                                 m_axis_tuser);
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= (pick_gap(stalls_on) == 0);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("** icosahedron_voxel_density_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = ivd_pkg::REG_GRID_SIDE;
        cfg_data      = '0;
        mismatches    = 0;
        results_seen  = 0;
        items_sent    = 0;
        hold_left     = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        face_hits     = '{0, 0, 0, 0};
        cur_side      = 64;
        cur_radius    = 5120;
        cur_rotate    = 1'b0;
        cur_quat      = '{32767, 0, 0, 0};
        build_rotation();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (MATRIX_SETTLE) @(posedge clk);

        test_directed();
        test_random_settings();
        test_backpressure();
        drain();

        $display("%0d voxels sent, %0d results checked over many grid, radius and rotation",
                 items_sent, results_seen);
        $display("face hits: %0d %0d %0d %0d", face_hits[0], face_hits[1], face_hits[2],
                 face_hits[3]);
        if (mismatches == 0 && density_q.size() == 0)
            $display("** icosahedron_voxel_density_unit: PASSED **");
        else
            $display("** icosahedron_voxel_density_unit: FAILED **");
        $finish;
    end

endmodule

>>> icosahedron_voxel_density_unit.f
sv/ivd_pkg.sv
sv/ivd_matrix.sv
sv/icosahedron_voxel_density_unit.sv
tb/sv/tb_icosahedron_voxel_density_unit.sv
